// ===== rtl/fwt_pkg.sv =====
// Shared constants and types for the modular binary indexed tree core.
// Used by fwt_ctrl, fwt_datapath and fenwick_tree_mod_prefix_sum_core; no dependencies.
package fwt_pkg;

    // Storage geometry.
    localparam int MAX_ENTRIES = 65536;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);

    // Field widths of the request, result and size register.
    localparam int IDX_W  = 17;
    localparam int VAL_W  = 30;
    localparam int WALK_W = IDX_W + 1;

    // Modulus of the residue arithmetic.
    localparam logic [VAL_W-1:0] RESIDUE_PRIME = 30'd1000000007;

    // Table size after reset and largest usable position.
    localparam logic [IDX_W-1:0] SIZE_RESET = 17'd65536;
    localparam logic [IDX_W-1:0] MAX_POS    = IDX_W'(MAX_ENTRIES);

    // Request kinds.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic walk_end;
    } status_t;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLEAR = 3'b010,
        ST_WALK  = 3'b100
    } state_t;

endpackage

// ===== rtl/fenwick_tree_mod_prefix_sum_core.sv =====
// Top level of the modular binary indexed tree core.
// Instantiates fwt_ctrl and fwt_datapath; depends on fwt_pkg.
//
// After reset the block clears its 65536-entry tree memory, one entry per cycle,
// and holds busy high until clearing is over; table_size writes are taken during
// that time. A request is transferred at a clock edge with start high and busy low.
// It then keeps busy high while the walk visits its tree nodes; the walk makes
// one memory read and at most one write per cycle with the read data registered.
// A query delivers its prefix_sum with done high for exactly one cycle, the first
// cycle with busy low again; the receiver cannot stall, so prefix_sum must be
// captured in that cycle. Updates deliver nothing.
module fenwick_tree_mod_prefix_sum_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        req_type,
    input  logic [fwt_pkg::IDX_W-1:0]   index,
    input  logic [fwt_pkg::VAL_W-1:0]   value,
    input  logic                        table_size_we,
    input  logic [fwt_pkg::IDX_W-1:0]   table_size,
    output logic                        done,
    output logic [fwt_pkg::VAL_W-1:0]   prefix_sum
);

    fwt_pkg::cmd_t    cmd;
    fwt_pkg::status_t status;

    // Sequencing of clearing and tree walks.
    fwt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Storage and arithmetic.
    fwt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .table_size_we (table_size_we),
        .table_size    (table_size),
        .req_type      (req_type),
        .index         (index),
        .value         (value),
        .done          (done),
        .prefix_sum    (prefix_sum)
    );

endmodule

// ===== rtl/fwt_ctrl.sv =====
// Controller state machine for the modular binary indexed tree core.
// Depends on fwt_pkg for the state, command and status types.
module fwt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fwt_pkg::status_t status,
    output fwt_pkg::cmd_t    cmd,
    output logic             busy
);

    fwt_pkg::state_t state_reg;
    fwt_pkg::state_t state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fwt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            fwt_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = fwt_pkg::ST_IDLE;
                end
            end
            fwt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = fwt_pkg::ST_WALK;
                end
            end
            fwt_pkg::ST_WALK:
            begin
                if (status.walk_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = fwt_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = fwt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fwt_datapath.sv =====
// Datapath of the modular binary indexed tree core: size register, tree memory,
// walk position, modular adders and result register. Depends on fwt_pkg.
module fwt_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fwt_pkg::cmd_t               cmd,
    output fwt_pkg::status_t            status,
    input  logic                        table_size_we,
    input  logic [fwt_pkg::IDX_W-1:0]   table_size,
    input  logic                        req_type,
    input  logic [fwt_pkg::IDX_W-1:0]   index,
    input  logic [fwt_pkg::VAL_W-1:0]   value,
    output logic                        done,
    output logic [fwt_pkg::VAL_W-1:0]   prefix_sum
);

    logic [fwt_pkg::VAL_W-1:0]  mem [fwt_pkg::MAX_ENTRIES];

    logic [fwt_pkg::IDX_W-1:0]  size_reg;
    logic [fwt_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic                       kind_reg;
    logic [fwt_pkg::VAL_W-1:0]  val_reg;
    logic [fwt_pkg::VAL_W-1:0]  acc_reg;
    logic [fwt_pkg::WALK_W-1:0] pos_reg;
    logic [fwt_pkg::VAL_W-1:0]  rdata_reg;
    logic                       done_reg;
    logic [fwt_pkg::VAL_W-1:0]  sum_reg;

    logic [fwt_pkg::IDX_W-1:0]  limit;
    logic [fwt_pkg::IDX_W-1:0]  start_pos;
    logic [fwt_pkg::VAL_W-1:0]  val_red;
    logic                       pos_ok;
    logic [fwt_pkg::WALK_W-1:0] low_bit;
    logic [fwt_pkg::WALK_W-1:0] pos_next;
    logic [fwt_pkg::VAL_W:0]    add_raw;
    logic [fwt_pkg::VAL_W-1:0]  add_mod;
    logic [fwt_pkg::WALK_W-1:0] rd_pos;
    logic [fwt_pkg::WALK_W-1:0] rd_pos_m1;
    logic [fwt_pkg::WALK_W-1:0] wr_pos_m1;
    logic [fwt_pkg::ADDR_W-1:0] raddr;
    logic [fwt_pkg::ADDR_W-1:0] waddr;
    logic [fwt_pkg::VAL_W-1:0]  wdata;
    logic                       we;

    // Usable size: the register saturated to the storage depth.
    assign limit = (size_reg > fwt_pkg::MAX_POS) ? fwt_pkg::MAX_POS : size_reg;

    // A query starts at its index clamped to the size; an update at its index.
    assign start_pos = (req_type == fwt_pkg::REQ_QUERY && index > limit) ? limit : index;

    // The value is below twice the prime, so one subtraction reduces it.
    assign val_red = (value >= fwt_pkg::RESIDUE_PRIME) ? (value - fwt_pkg::RESIDUE_PRIME)
                                                       : value;

    // A position takes part in the walk while it lies in 1..limit.
    assign pos_ok = (pos_reg != '0) && (pos_reg <= {1'b0, limit});

    // Next position: add the lowest set bit going up, clear it going down.
    assign low_bit  = pos_reg & (~pos_reg + 1'b1);
    assign pos_next = (kind_reg == fwt_pkg::REQ_QUERY) ? (pos_reg & ~low_bit)
                                                       : (pos_reg + low_bit);

    // Modular add of the stored entry to the update value or the running sum.
    assign add_raw = {1'b0, rdata_reg}
                   + {1'b0, (kind_reg == fwt_pkg::REQ_QUERY) ? acc_reg : val_reg};
    assign add_mod = (add_raw >= {1'b0, fwt_pkg::RESIDUE_PRIME})
                   ? fwt_pkg::VAL_W'(add_raw - {1'b0, fwt_pkg::RESIDUE_PRIME})
                   : add_raw[fwt_pkg::VAL_W-1:0];

    // Memory addresses: entry n sits at address n - 1.
    assign rd_pos    = cmd.load ? {1'b0, start_pos} : pos_next;
    assign rd_pos_m1 = rd_pos - 1'b1;
    assign wr_pos_m1 = pos_reg - 1'b1;
    assign raddr     = rd_pos_m1[fwt_pkg::ADDR_W-1:0];
    assign waddr     = cmd.clear ? clr_cnt_reg : wr_pos_m1[fwt_pkg::ADDR_W-1:0];
    assign wdata     = cmd.clear ? '0 : add_mod;
    assign we        = cmd.clear || (cmd.step && kind_reg == fwt_pkg::REQ_UPDATE);

    // Tree memory: at most one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Control registers: size, clearing counter and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= fwt_pkg::SIZE_RESET;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (table_size_we)
            begin
                size_reg <= table_size;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= cmd.finish && (kind_reg == fwt_pkg::REQ_QUERY);
        end
    end

    // Walk registers: request fields, position and running sum.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req_type;
            val_reg  <= val_red;
            acc_reg  <= '0;
            pos_reg  <= {1'b0, start_pos};
        end
        else if (cmd.step)
        begin
            pos_reg <= pos_next;
            if (kind_reg == fwt_pkg::REQ_QUERY)
            begin
                acc_reg <= add_mod;
            end
        end
        if (cmd.finish)
        begin
            sum_reg <= acc_reg;
        end
    end

    assign status.clear_last = (clr_cnt_reg == fwt_pkg::ADDR_W'(fwt_pkg::MAX_ENTRIES - 1));
    assign status.walk_end   = !pos_ok;

    assign done       = done_reg;
    assign prefix_sum = sum_reg;

endmodule
